// ----- hdl/ctl_pkg.sv -----
// Package for the closed tour length block: transaction types and sequencer states.
package ctl_pkg;

	// Widths of the fields on the ports.
	localparam int POINT_FIELD_BITS = 16;
	localparam int LENGTH_FIELD_BITS = 48;

	// One tour point, as carried on the input channel.
	typedef struct packed {
		logic signed [POINT_FIELD_BITS-1:0] point_x;
		logic signed [POINT_FIELD_BITS-1:0] point_y;
		logic                               last_point;
	} point_t;

	// One tour result, as carried on the output channel.
	typedef struct packed {
		logic [LENGTH_FIELD_BITS-1:0] tour_length;
		logic                         saturated;
	} result_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SQ_X,
		ST_SQ_Y,
		ST_ROOT,
		ST_ACC,
		ST_EMIT
	} seq_state_t;

endpackage

// ----- hdl/closed_tour_length.sv -----
// Closed tour length: sums Euclidean segment lengths of a tour with a shared square root unit.
//
// Points of a tour arrive one transaction at a time on the input channel (in_valid, in_ready,
// in_data). The point flagged last_point closes the tour: the segment back to the first point
// is added and one result transaction (tour_length, saturated) leaves on the output channel.
// Each segment length is floor(sqrt(dx*dx + dy*dy) * 2^FRAC_BITS), summed exactly in a
// TOTAL_BITS accumulator that saturates and raises a sticky flag.
//
// One shared multiplier squares dx and then dy, and one bit-serial square root unit takes
// COORD_BITS + FRAC_BITS + 1 iterations per segment; the root loop sets the timing. A first
// point that does not close the tour only passes the start step; a middle point is squared,
// rooted and accumulated. A closing point measures two segments, or one for a one-point
// tour, and its result is loaded into the output register after the last accumulation.
// in_ready is high only while the sequencer is idle.
//
// The result sits in an output register. When the receiver stalls, the sequencer waits with
// the finished total until the register is free. Reset clears the tour state, the total and
// the output valid flag; the first point after reset starts a new tour.
module closed_tour_length #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8,
	parameter int TOTAL_BITS = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ctl_pkg::point_t  in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ctl_pkg::result_t out_data
);
	import ctl_pkg::*;

	// Derived widths: root bits, radicand bits, accumulator compare width.
	localparam int ROOT_BITS = COORD_BITS + FRAC_BITS + 1;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int SQ_BITS   = 2 * (COORD_BITS + 1);
	localparam int CNT_BITS  = $clog2(ROOT_BITS);
	localparam int SUM_BITS  = ((TOTAL_BITS > ROOT_BITS) ? TOTAL_BITS : ROOT_BITS) + 1;
	localparam logic [SUM_BITS-1:0] TOTAL_MAX = (SUM_BITS'(1) << TOTAL_BITS) - SUM_BITS'(1);

	seq_state_t state_q, state_d;

	// Latched point and tour state.
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                  last_q;
	logic                  started_q;
	logic                  closing_q;
	logic                  overflow_q;
	logic [TOTAL_BITS-1:0] total_q;

	// Square root datapath.
	logic [SQ_BITS-1:0]   sq_x_q;
	logic [RAD_BITS-1:0]  rad_q;
	logic [ROOT_BITS:0]   rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_BITS-1:0]  cnt_q;

	// Output register.
	logic    out_valid_q;
	result_t out_data_q;

	logic [COORD_BITS-1:0] in_x, in_y;
	logic [COORD_BITS-1:0] seg_ax, seg_ay;
	logic [COORD_BITS:0]   dx, dy, adx, ady, mul_in;
	logic [SQ_BITS-1:0]    mul_out;
	logic [SQ_BITS-1:0]    sq_sum;
	logic [ROOT_BITS+2:0]  trial, cand, diff;
	logic                  take;
	logic [SUM_BITS-1:0]   acc_sum;
	logic                  acc_over;
	logic                  accept;
	logic                  emit_load;

	// Coordinates: low COORD_BITS of the field, sign-extended above the field width.
	if (COORD_BITS <= POINT_FIELD_BITS) begin : g_coord_narrow
		assign in_x = in_data.point_x[COORD_BITS-1:0];
		assign in_y = in_data.point_y[COORD_BITS-1:0];
	end else begin : g_coord_wide
		assign in_x = {{(COORD_BITS-POINT_FIELD_BITS){in_data.point_x[POINT_FIELD_BITS-1]}},
			in_data.point_x};
		assign in_y = {{(COORD_BITS-POINT_FIELD_BITS){in_data.point_y[POINT_FIELD_BITS-1]}},
			in_data.point_y};
	end

	// Segment end points: the previous point, or the first point when closing the tour.
	assign seg_ax = closing_q ? first_x_q : prev_x_q;
	assign seg_ay = closing_q ? first_y_q : prev_y_q;
	assign dx     = {seg_ax[COORD_BITS-1], seg_ax} - {cur_x_q[COORD_BITS-1], cur_x_q};
	assign dy     = {seg_ay[COORD_BITS-1], seg_ay} - {cur_y_q[COORD_BITS-1], cur_y_q};
	assign adx    = dx[COORD_BITS] ? -dx : dx;
	assign ady    = dy[COORD_BITS] ? -dy : dy;

	// The shared multiplier squares dx first, then dy.
	assign mul_in  = (state_q == ST_SQ_X) ? adx : ady;
	assign mul_out = mul_in * mul_in;
	assign sq_sum  = sq_x_q + mul_out;

	// One restoring square root step: two radicand bits in, one root bit out.
	assign trial = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign cand  = {1'b0, root_q, 2'b01};
	assign take  = (trial >= cand);
	assign diff  = trial - cand;

	// Saturating accumulation of the finished segment.
	assign acc_sum  = SUM_BITS'(total_q) + SUM_BITS'(root_q);
	assign acc_over = (acc_sum > TOTAL_MAX);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: begin
				if (started_q || last_q) state_d = ST_SQ_X;
				else state_d = ST_IDLE;
			end
			ST_SQ_X: state_d = ST_SQ_Y;
			ST_SQ_Y: state_d = ST_ROOT;
			ST_ROOT: begin
				if (cnt_q == '0) state_d = ST_ACC;
			end
			ST_ACC: begin
				if (closing_q) state_d = ST_EMIT;
				else if (last_q) state_d = ST_SQ_X;
				else state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Handshake and strobes decoded from the state.
	always_comb begin
		in_ready  = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EMIT: emit_load = !out_valid_q || out_ready;
			default: begin
				in_ready  = 1'b0;
				emit_load = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// Sequencer and tour control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			started_q  <= 1'b0;
			closing_q  <= 1'b0;
			overflow_q <= 1'b0;
			total_q    <= '0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_START: begin
					closing_q <= !started_q;
					if (!started_q) begin
						first_x_q  <= cur_x_q;
						first_y_q  <= cur_y_q;
						prev_x_q   <= cur_x_q;
						prev_y_q   <= cur_y_q;
						total_q    <= '0;
						overflow_q <= 1'b0;
						started_q  <= 1'b1;
					end
				end
				ST_ACC: begin
					if (acc_over) begin
						total_q    <= TOTAL_MAX[TOTAL_BITS-1:0];
						overflow_q <= 1'b1;
					end else begin
						total_q <= acc_sum[TOTAL_BITS-1:0];
					end
					if (!closing_q) begin
						prev_x_q  <= cur_x_q;
						prev_y_q  <= cur_y_q;
						closing_q <= last_q;
					end else begin
						started_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Point capture and square root datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_x_q <= in_x;
			cur_y_q <= in_y;
			last_q  <= in_data.last_point;
		end
		case (state_q)
			ST_SQ_X: sq_x_q <= mul_out;
			ST_SQ_Y: begin
				rad_q  <= RAD_BITS'(sq_sum) << (2 * FRAC_BITS);
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_BITS'(ROOT_BITS - 1);
			end
			ST_ROOT: begin
				rem_q  <= take ? diff[ROOT_BITS:0] : trial[ROOT_BITS:0];
				root_q <= {root_q[ROOT_BITS-2:0], take};
				rad_q  <= rad_q << 2;
				cnt_q  <= cnt_q - CNT_BITS'(1);
			end
			default: begin
			end
		endcase
	end

	// Output register: the finished total waits here for the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q.tour_length <= LENGTH_FIELD_BITS'(total_q);
			out_data_q.saturated   <= overflow_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// An accepted point is always taken up by the start step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_START))
		else $error("accepted point did not enter the start step");

	// The root loop hands over to accumulation once its last bit is done.
	a_root_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT && cnt_q == '0) |=> (state_q == ST_ACC))
		else $error("square root loop did not end in accumulation");

	// A segment from the previous point is only measured inside a started tour.
	a_segment_in_tour: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ_X && !closing_q) |-> started_q)
		else $error("segment measured outside a tour");

	// A saturated result carries the accumulator maximum.
	a_saturated_max: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && overflow_q) |-> (total_q == TOTAL_MAX[TOTAL_BITS-1:0]))
		else $error("saturated total is not at its maximum");

endmodule
